[rtl/core/sobel_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel edge magnitude package
// Beat types, register indexes and reset values shared by the edge filter.
// ----------------------------------------------------------------------------
package sobel_pkg;

  // Fixed field widths
  localparam int unsigned PixelW    = 8;
  localparam int unsigned OutRowW   = 12;
  localparam int unsigned OutColW   = 10;
  localparam int unsigned FrameWidthW  = 11;
  localparam int unsigned FrameHeightW = 13;
  localparam int unsigned CfgDataW  = 13;
  localparam int unsigned CfgIdxW   = 1;

  // Default geometry limits
  localparam int unsigned DefMaxWidth  = 1024;
  localparam int unsigned DefMaxHeight = 4096;

  // Register reset values
  localparam logic [FrameWidthW-1:0]  FrameWidthRst  = 11'd1024;
  localparam logic [FrameHeightW-1:0] FrameHeightRst = 13'd1024;

  // Smallest legal frame dimension
  localparam int unsigned MinDim = 3;

  // Saturation limit of the magnitude
  localparam int unsigned MagMax = 255;

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [PixelW-1:0] pixel;
    logic              frame_start;
  } pix_in_t;

  typedef struct packed {
    logic [OutRowW-1:0] out_row;
    logic [OutColW-1:0] out_col;
    logic [PixelW-1:0]  magnitude;
    logic               frame_end;
  } pix_out_t;

endpackage

[rtl/core/sobel_edge_magnitude_3x3.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel 3x3 edge magnitude
// Streaming |Gx|+|Gy| filter on 8-bit grey pixels with two line memories.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one beat per clock at full rate. When pixel
// (r,c) with r>=1 and c>=1 is taken, one output beat follows for the centre
// (r-1,c-1): its position, the saturated Sobel magnitude (0 for a centre in
// row 0 or column 0) and frame_end on centre (height-2,width-2). Pixels in row
// 0 or column 0 give no output beat. An input beat reaches the output through
// the line memory read, the window update with write-back and the magnitude
// register. The rate is one pixel per cycle, set by the single read-modify-
// write per line memory and pixel; a stall on the output holds the whole
// pipeline. frame_start restarts the position counters only; without it the
// counters wrap on their own after the last pixel of a frame. frame_width and
// frame_height are clamped to [3, MAX_WIDTH] and [3, MAX_HEIGHT] when used;
// change them only while no beat is in flight. No clearing pass after reset.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_3x3 #(
  parameter int unsigned MAX_WIDTH  = sobel_pkg::DefMaxWidth,
  parameter int unsigned MAX_HEIGHT = sobel_pkg::DefMaxHeight
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Pixel input
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  sobel_pkg::pix_in_t              in_data_i,
  // Result output
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output sobel_pkg::pix_out_t             out_data_o,
  // Register writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [sobel_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [sobel_pkg::CfgDataW-1:0]  cfg_data_i
);

  // Column / row counter widths and the widths the clamp needs
  localparam int unsigned CW  = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
  localparam int unsigned RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned WXW = ($clog2(MAX_WIDTH + 1) > sobel_pkg::FrameWidthW) ?
                                $clog2(MAX_WIDTH + 1) : sobel_pkg::FrameWidthW;
  localparam int unsigned HXW = ($clog2(MAX_HEIGHT + 1) > sobel_pkg::FrameHeightW) ?
                                $clog2(MAX_HEIGHT + 1) : sobel_pkg::FrameHeightW;
  localparam int unsigned CXW = (CW > sobel_pkg::OutColW) ? CW : sobel_pkg::OutColW;
  localparam int unsigned RXW = (RW > sobel_pkg::OutRowW) ? RW : sobel_pkg::OutRowW;
  localparam int unsigned PW  = sobel_pkg::PixelW;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [sobel_pkg::FrameWidthW-1:0]  frame_width_q;
  logic [sobel_pkg::FrameHeightW-1:0] frame_height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= sobel_pkg::FrameWidthRst;
      frame_height_q <= sobel_pkg::FrameHeightRst;
    end else if (cfg_valid_i) begin
      case (sobel_pkg::cfg_idx_e'(cfg_index_i))
        sobel_pkg::CFG_FRAME_WIDTH: begin
          frame_width_q <= cfg_data_i[sobel_pkg::FrameWidthW-1:0];
        end
        sobel_pkg::CFG_FRAME_HEIGHT: begin
          frame_height_q <= cfg_data_i[sobel_pkg::FrameHeightW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Clamped geometry, expressed as last column / last row
  logic [WXW-1:0] w_ext, w_eff;
  logic [HXW-1:0] h_ext, h_eff;
  logic [CW-1:0]  col_last;
  logic [RW-1:0]  row_last;

  always_comb begin
    w_ext = WXW'(frame_width_q);
    h_ext = HXW'(frame_height_q);
    if (w_ext < WXW'(sobel_pkg::MinDim))  w_eff = WXW'(sobel_pkg::MinDim);
    else if (w_ext > WXW'(MAX_WIDTH))     w_eff = WXW'(MAX_WIDTH);
    else                                  w_eff = w_ext;
    if (h_ext < HXW'(sobel_pkg::MinDim))  h_eff = HXW'(sobel_pkg::MinDim);
    else if (h_ext > HXW'(MAX_HEIGHT))    h_eff = HXW'(MAX_HEIGHT);
    else                                  h_eff = h_ext;
    col_last = CW'(w_eff - WXW'(1));
    row_last = RW'(h_eff - HXW'(1));
  end

  // --------------------------------------------------------------------------
  // Pipeline control: one enable for all stages, output stall holds everything
  // --------------------------------------------------------------------------
  logic out_valid_q;
  logic adv;
  logic accept;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;
  assign accept     = in_valid_i && adv;

  // --------------------------------------------------------------------------
  // Stage 0: position counters, line memory read
  // --------------------------------------------------------------------------
  logic [CW-1:0] col_q, col_d, c_cur;
  logic [RW-1:0] row_q, row_d, r_cur;
  logic [CXW-1:0] ocol_x;
  logic [RXW-1:0] orow_x;

  always_comb begin
    c_cur = in_data_i.frame_start ? '0 : col_q;
    r_cur = in_data_i.frame_start ? '0 : row_q;
    if (c_cur >= col_last) begin
      col_d = '0;
      row_d = (r_cur >= row_last) ? '0 : r_cur + RW'(1);
    end else begin
      col_d = c_cur + CW'(1);
      row_d = r_cur;
    end
    ocol_x = CXW'(c_cur) - CXW'(1);
    orow_x = RXW'(r_cur) - RXW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Line memories: upper holds row r-2, middle holds row r-1
  logic [PW-1:0] mem_upper [MAX_WIDTH];
  logic [PW-1:0] mem_middle [MAX_WIDTH];
  logic [PW-1:0] rd_upper_q, rd_middle_q;

  // Stage 1 registers
  logic                           s1_valid_q;
  logic [PW-1:0]                  s1_px_q;
  logic [CW-1:0]                  s1_col_q;
  logic                           s1_rge1_q, s1_rge2_q;
  logic                           s1_emit_q, s1_zero_q, s1_fend_q;
  logic [sobel_pkg::OutRowW-1:0]  s1_orow_q;
  logic [sobel_pkg::OutColW-1:0]  s1_ocol_q;

  // Forwarding of the write-back that lands on the same edge as the read
  logic           fwd_up_q, fwd_mid_q;
  logic [PW-1:0]  fwd_up_val_q, fwd_mid_val_q;
  logic           fwd_hit;

  logic [PW-1:0]  top_px, mid_px;
  logic           s1_wr;

  assign fwd_hit = s1_valid_q && (s1_col_q == c_cur);
  assign s1_wr   = s1_valid_q && adv;

  always_comb begin
    if (!s1_rge2_q)    top_px = '0;
    else if (fwd_up_q) top_px = fwd_up_val_q;
    else               top_px = rd_upper_q;
    if (!s1_rge1_q)     mid_px = '0;
    else if (fwd_mid_q) mid_px = fwd_mid_val_q;
    else                mid_px = rd_middle_q;
  end

  // Read on accept, write back as the stage-1 beat moves on
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_upper_q  <= mem_upper[c_cur];
      rd_middle_q <= mem_middle[c_cur];
    end
    if (s1_wr) begin
      mem_middle[s1_col_q] <= s1_px_q;
      if (s1_rge1_q) begin
        mem_upper[s1_col_q] <= mid_px;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_px_q       <= in_data_i.pixel;
      s1_col_q      <= c_cur;
      s1_rge1_q     <= (r_cur >= RW'(1));
      s1_rge2_q     <= (r_cur >= RW'(2));
      s1_emit_q     <= (r_cur != '0) && (c_cur != '0);
      s1_zero_q     <= (r_cur == RW'(1)) || (c_cur == CW'(1));
      s1_fend_q     <= (r_cur == row_last) && (c_cur == col_last);
      s1_orow_q     <= orow_x[sobel_pkg::OutRowW-1:0];
      s1_ocol_q     <= ocol_x[sobel_pkg::OutColW-1:0];
      fwd_up_val_q  <= mid_px;
      fwd_mid_val_q <= s1_px_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_up_q   <= 1'b0;
      fwd_mid_q  <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= accept;
      if (accept) begin
        fwd_mid_q <= fwd_hit;
        fwd_up_q  <= fwd_hit && s1_rge1_q;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1 -> 2: 3x3 window shift. win_q[row][col], col 2 is newest.
  // --------------------------------------------------------------------------
  logic [PW-1:0] win_q [3][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[i][j] <= '0;
        end
      end
    end else if (s1_wr) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i][0] <= win_q[i][1];
        win_q[i][1] <= win_q[i][2];
      end
      win_q[0][2] <= top_px;
      win_q[1][2] <= mid_px;
      win_q[2][2] <= s1_px_q;
    end
  end

  // Stage 2 registers: only beats that produce output
  logic                           s2_valid_q;
  logic                           s2_zero_q, s2_fend_q;
  logic [sobel_pkg::OutRowW-1:0]  s2_orow_q;
  logic [sobel_pkg::OutColW-1:0]  s2_ocol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s2_valid_q <= s1_valid_q && s1_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_wr) begin
      s2_zero_q <= s1_zero_q;
      s2_fend_q <= s1_fend_q;
      s2_orow_q <= s1_orow_q;
      s2_ocol_q <= s1_ocol_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: Sobel gradients, |Gx|+|Gy| saturated
  // --------------------------------------------------------------------------
  logic signed [10:0] gx, gy;
  logic        [9:0]  gx_abs, gy_abs;
  logic        [10:0] mag_sum;
  logic [PW-1:0]      mag;

  always_comb begin
    gx = $signed({3'b000, win_q[0][0]}) + $signed({2'b00, win_q[1][0], 1'b0})
       + $signed({3'b000, win_q[2][0]}) - $signed({3'b000, win_q[0][2]})
       - $signed({2'b00, win_q[1][2], 1'b0}) - $signed({3'b000, win_q[2][2]});
    gy = $signed({3'b000, win_q[0][0]}) + $signed({2'b00, win_q[0][1], 1'b0})
       + $signed({3'b000, win_q[0][2]}) - $signed({3'b000, win_q[2][0]})
       - $signed({2'b00, win_q[2][1], 1'b0}) - $signed({3'b000, win_q[2][2]});
    gx_abs  = gx[10] ? 10'(-gx) : gx[9:0];
    gy_abs  = gy[10] ? 10'(-gy) : gy[9:0];
    mag_sum = 11'(gx_abs) + 11'(gy_abs);
    if (s2_zero_q)                          mag = '0;
    else if (mag_sum > 11'(sobel_pkg::MagMax)) mag = PW'(sobel_pkg::MagMax);
    else                                    mag = mag_sum[PW-1:0];
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  sobel_pkg::pix_out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s2_valid_q) begin
      out_q.out_row   <= s2_orow_q;
      out_q.out_col   <= s2_ocol_q;
      out_q.magnitude <= mag;
      out_q.frame_end <= s2_fend_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
